// File: sv/second_order_tustin_filter_core_defines.svh
// ----------------------------------------------------------------------------
// Second-order Tustin filter core: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SECOND_ORDER_TUSTIN_FILTER_CORE_DEFINES_SVH
`define SECOND_ORDER_TUSTIN_FILTER_CORE_DEFINES_SVH

// same-cycle implication
`define TFC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/tfc_pkg.sv
// ----------------------------------------------------------------------------
// Second-order Tustin filter package
// Types, sequencer codes and fixed widths shared by the filter modules.
// ----------------------------------------------------------------------------
package tfc_pkg;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 66;
	localparam int ACC_W  = 67;
	localparam int P_W    = 50;

	localparam logic       OP_FILTER = 1'b0;
	localparam logic       OP_INIT   = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_UNINIT   = 2'd1;
	localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

	localparam logic [2:0] REG_NUM_C0    = 3'd0;
	localparam logic [2:0] REG_NUM_C1    = 3'd1;
	localparam logic [2:0] REG_NUM_C2    = 3'd2;
	localparam logic [2:0] REG_DEN_C0    = 3'd3;
	localparam logic [2:0] REG_DEN_C1    = 3'd4;
	localparam logic [2:0] REG_DEN_C2    = 3'd5;
	localparam logic [2:0] REG_STEP_SIZE = 3'd6;

	localparam logic [5:0] DIV_LAST = 6'd63;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		SQ_TSQ,
		SQ_T2,
		SQ_N0,
		SQ_N1,
		SQ_D0,
		SQ_BCO,
		SQ_D1,
		SQ_ACO,
		SQ_M1,
		SQ_M2,
		SQ_M3,
		SQ_M4,
		SQ_M5,
		SQ_CLAMP
	} seq_t;

	typedef struct packed {
		logic signed [31:0] num_c0;
		logic signed [31:0] num_c1;
		logic signed [31:0] num_c2;
		logic signed [31:0] den_c0;
		logic signed [31:0] den_c1;
		logic signed [31:0] den_c2;
		logic        [31:0] step_size;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

endpackage

// File: sv/tfc_regs.sv
// ----------------------------------------------------------------------------
// Second-order Tustin filter configuration registers
// APB-style register file holding the transfer function and the time step.
// ----------------------------------------------------------------------------
module tfc_regs
	import tfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t        cfg_q;
	logic [2:0]  idx;
	logic        wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_c0    <= 32'sd65536;
			cfg_q.num_c1    <= '0;
			cfg_q.num_c2    <= '0;
			cfg_q.den_c0    <= 32'sd65536;
			cfg_q.den_c1    <= '0;
			cfg_q.den_c2    <= '0;
			cfg_q.step_size <= 32'd65;
		end else if (wr_en) begin
			case (idx)
				REG_NUM_C0:    cfg_q.num_c0    <= pwdata;
				REG_NUM_C1:    cfg_q.num_c1    <= pwdata;
				REG_NUM_C2:    cfg_q.num_c2    <= pwdata;
				REG_DEN_C0:    cfg_q.den_c0    <= pwdata;
				REG_DEN_C1:    cfg_q.den_c1    <= pwdata;
				REG_DEN_C2:    cfg_q.den_c2    <= pwdata;
				REG_STEP_SIZE: cfg_q.step_size <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_NUM_C0:    prdata = cfg_q.num_c0;
			REG_NUM_C1:    prdata = cfg_q.num_c1;
			REG_NUM_C2:    prdata = cfg_q.num_c2;
			REG_DEN_C0:    prdata = cfg_q.den_c0;
			REG_DEN_C1:    prdata = cfg_q.den_c1;
			REG_DEN_C2:    prdata = cfg_q.den_c2;
			REG_STEP_SIZE: prdata = cfg_q.step_size;
			default:       prdata = '0;
		endcase
	end

endmodule

// File: sv/tfc_mul.sv
// ----------------------------------------------------------------------------
// Second-order Tustin filter shared multiplier
// Signed 33 x 33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module tfc_mul
	import tfc_pkg::*;
(
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] p
);

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// File: sv/tfc_div.sv
// ----------------------------------------------------------------------------
// Second-order Tustin filter divider
// Unsigned 64 / 32 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tfc_div
	import tfc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [63:0] quo_q;
	logic [32:0] sh;
	logic [32:0] diff;
	logic        fit;

	assign sh   = {rem_q, quo_q[63]};
	assign diff = sh - {1'b0, den_q};
	assign fit  = (sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_LAST);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == DIV_LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fit ? diff[31:0] : sh[31:0];
			quo_q <= {quo_q[62:0], fit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// File: sv/second_order_tustin_filter_core.sv
// ----------------------------------------------------------------------------
// Second-order Tustin filter core
// Bilinear-discretized second-order transfer function in Q16.16.
// ----------------------------------------------------------------------------
// Usage: coefficients and the time step are written over the APB port while
// the core is idle. Items arrive on sample_valid/sample_stall with op,
// sample, init_output and same_step; each gives one beat of filtered and
// status on result_valid/result_stall.
// An init item, a sample before init and a repeated step go from idle
// straight to the done state, which hands the result to the output register.
// A filter step runs the sequencer on the shared multiplier (T squared,
// the four coefficient products and the five difference-equation products),
// then the one-bit-per-cycle divider, and hands over through the done state.
// A zero leading denominator ends the step early, before the divider.
// The core takes one item at a time; sample_stall is high while it works.
// A finished result sits in the output register, so the next item is taken
// while the receiver stalls; the core then waits only if a second result is
// ready before the first beat is taken. Reset clears the histories and the
// init flag and loads the default coefficients.
// ----------------------------------------------------------------------------
`include "second_order_tustin_filter_core_defines.svh"

module second_order_tustin_filter_core
	import tfc_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic        op,
	input  logic signed [31:0] sample,
	input  logic signed [31:0] init_output,
	input  logic        same_step,
	output logic        result_valid,
	input  logic        result_stall,
	output logic signed [31:0] filtered,
	output logic [1:0]  status
);

	localparam int SAT_W = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((longint'(1) <<< (SAT_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-(longint'(1) <<< (SAT_W - 1)));
	localparam logic signed [ACC_W-1:0] MAX64 = {3'b000, 1'b0, {63{1'b1}}};
	localparam logic signed [ACC_W-1:0] MIN64 = {3'b111, 1'b1, {63{1'b0}}};
	localparam logic [63:0] LIM_U = 64'(longint'(1) <<< (SAT_W - 1));

	function automatic logic signed [31:0] sat_q(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX)
			r = SAT_MAX[31:0];
		else if (v < SAT_MIN)
			r = SAT_MIN[31:0];
		else
			r = v[31:0];
		return r;
	endfunction

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	state_t state_q, state_d;
	seq_t   step_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;

	logic               primed_q;
	logic signed [31:0] u0_q, uh1_q, uh2_q, yh1_q, yh2_q;
	logic        [31:0] t2_q;
	logic signed [P_W-1:0] p0_q, p1_q;
	logic signed [31:0] b0_q, b1_q, b2_q, a0_q, a1_q, a2_q;
	logic signed [ACC_W-1:0] acc_q;
	logic               neg_q;
	logic signed [31:0] res_y_q;
	logic [1:0]         res_st_q;
	logic               result_valid_q;
	logic signed [31:0] filtered_q;
	logic [1:0]         status_q;

	logic               accept, quick, out_free;
	logic signed [31:0] c2_sel;
	logic signed [31:0] k0, k1, k2;
	logic signed [ACC_W-1:0] prod_ext, p_shift_ext;
	logic signed [63:0] acc64;
	logic        [63:0] mag;
	logic signed [31:0] y_new;

	tfc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tfc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	tfc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept   = sample_valid && !sample_stall;
	assign quick    = (op == OP_INIT) || !primed_q || same_step;
	assign out_free = !result_valid_q || !result_stall;

	// shared coefficient adder: numerator at SQ_BCO, denominator at SQ_ACO
	assign c2_sel = (step_q == SQ_BCO) ? cfg.num_c2 : cfg.den_c2;
	assign k0 = sat_q((ACC_W'(c2_sel) <<< 2) + ACC_W'(p0_q) + (ACC_W'(p1_q) <<< 1));
	assign k1 = sat_q(-(ACC_W'(c2_sel) <<< 3) + (ACC_W'(p0_q) <<< 1));
	assign k2 = sat_q((ACC_W'(c2_sel) <<< 2) + ACC_W'(p0_q) - (ACC_W'(p1_q) <<< 1));

	assign prod_ext    = ACC_W'(prod);
	assign p_shift_ext = ACC_W'(prod >>> 16);

	always_comb begin
		if (acc_q > MAX64)
			acc64 = MAX64[63:0];
		else if (acc_q < MIN64)
			acc64 = MIN64[63:0];
		else
			acc64 = acc_q[63:0];
		mag = acc64[63] ? (64'd0 - acc64) : acc64;
	end

	always_comb begin
		if (!neg_q)
			y_new = (div_rsp.quotient > (LIM_U - 64'd1)) ? SAT_MAX[31:0] :
				div_rsp.quotient[31:0];
		else
			y_new = (div_rsp.quotient > LIM_U) ? SAT_MIN[31:0] :
				32'(64'd0 - div_rsp.quotient);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = quick ? ST_DONE : ST_CALC;
			end
			ST_CALC: begin
				if (step_q == SQ_ACO && k0 == 32'sd0)
					state_d = ST_DONE;
				else if (step_q == SQ_CLAMP)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_rsp.done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		sample_stall     = (state_q != ST_IDLE);
		mul_a            = '0;
		mul_b            = '0;
		div_req.start    = (state_q == ST_CALC) && (step_q == SQ_CLAMP);
		div_req.dividend = mag;
		div_req.divisor  = a0_q[31] ? (32'd0 - a0_q) : a0_q;
		case (step_q)
			SQ_TSQ: begin
				mul_a = $signed({1'b0, cfg.step_size});
				mul_b = $signed({1'b0, cfg.step_size});
			end
			SQ_N0: begin
				mul_a = MUL_W'(cfg.num_c0);
				mul_b = $signed({1'b0, t2_q});
			end
			SQ_N1: begin
				mul_a = MUL_W'(cfg.num_c1);
				mul_b = $signed({1'b0, cfg.step_size});
			end
			SQ_D0: begin
				mul_a = MUL_W'(cfg.den_c0);
				mul_b = $signed({1'b0, t2_q});
			end
			SQ_BCO: begin
				mul_a = MUL_W'(cfg.den_c1);
				mul_b = $signed({1'b0, cfg.step_size});
			end
			SQ_ACO: begin
				mul_a = MUL_W'(b0_q);
				mul_b = MUL_W'(u0_q);
			end
			SQ_M1: begin
				mul_a = MUL_W'(b1_q);
				mul_b = MUL_W'(uh1_q);
			end
			SQ_M2: begin
				mul_a = MUL_W'(b2_q);
				mul_b = MUL_W'(uh2_q);
			end
			SQ_M3: begin
				mul_a = -MUL_W'(a1_q);
				mul_b = MUL_W'(yh1_q);
			end
			SQ_M4: begin
				mul_a = -MUL_W'(a2_q);
				mul_b = MUL_W'(yh2_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			step_q         <= SQ_TSQ;
			primed_q       <= 1'b0;
			uh1_q          <= '0;
			uh2_q          <= '0;
			yh1_q          <= '0;
			yh2_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= (state_q == ST_DONE && out_free) ||
				(result_valid_q && result_stall);
			case (state_q)
				ST_IDLE: begin
					step_q <= SQ_TSQ;
					if (accept && op == OP_INIT) begin
						uh1_q    <= sat_q(ACC_W'(sample));
						uh2_q    <= sat_q(ACC_W'(sample));
						yh1_q    <= sat_q(ACC_W'(init_output));
						yh2_q    <= sat_q(ACC_W'(init_output));
						primed_q <= 1'b1;
					end
				end
				ST_CALC: begin
					if (step_q != SQ_CLAMP)
						step_q <= seq_t'(step_q + 4'd1);
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						uh2_q <= uh1_q;
						uh1_q <= u0_q;
						yh2_q <= yh1_q;
						yh1_q <= y_new;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			u0_q <= sat_q(ACC_W'(sample));
			if (op == OP_INIT) begin
				res_y_q  <= sat_q(ACC_W'(init_output));
				res_st_q <= STATUS_OK;
			end else begin
				res_y_q  <= yh1_q;
				res_st_q <= primed_q ? STATUS_OK : STATUS_UNINIT;
			end
		end
		if (state_q == ST_CALC) begin
			case (step_q)
				SQ_T2:  t2_q <= sat_q(p_shift_ext);
				SQ_N1:  p0_q <= P_W'(prod >>> 16);
				SQ_D0:  p1_q <= P_W'(prod >>> 16);
				SQ_BCO: begin
					b0_q <= k0;
					b1_q <= k1;
					b2_q <= k2;
					p0_q <= P_W'(prod >>> 16);
				end
				SQ_D1:  p1_q <= P_W'(prod >>> 16);
				SQ_ACO: begin
					a0_q     <= k0;
					a1_q     <= k1;
					a2_q     <= k2;
					res_y_q  <= yh1_q;
					res_st_q <= STATUS_DIV_ZERO;
				end
				SQ_M1:    acc_q <= prod_ext;
				SQ_M2, SQ_M3, SQ_M4, SQ_M5: acc_q <= acc_q + prod_ext;
				SQ_CLAMP: neg_q <= acc64[63] ^ a0_q[31];
				default: ;
			endcase
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			res_y_q  <= y_new;
			res_st_q <= STATUS_OK;
		end
		if (state_q == ST_DONE && out_free) begin
			filtered_q <= res_y_q;
			status_q   <= res_st_q;
		end
	end

	assign result_valid = result_valid_q;
	assign filtered     = filtered_q;
	assign status       = status_q;

	`TFC_ASSERT_NEXT(a_busy_after_accept, accept, (state_q != ST_IDLE), "item accepted but sequencer idle")
	`TFC_ASSERT_SAME(a_div_nonzero, (state_q == ST_DIV), (div_req.divisor != 32'd0), "divide by zero a0")
	`TFC_ASSERT_SAME(a_status_code, result_valid, (status == STATUS_OK || status == STATUS_UNINIT || status == STATUS_DIV_ZERO), "bad status code")

endmodule

// File: tb/tb_second_order_tustin_filter_core.sv
// ----------------------------------------------------------------------------
// Second-order Tustin filter core testbench
// Drives init and filter beats with random gaps and result stalls, and
// programs several coefficient sets (the extremes among them) over APB
// between phases. Every result beat is checked against a table row or an
// in-bench bilinear Q16.16 predictor, with saturation and a zero-a0 flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_second_order_tustin_filter_core;
	import tfc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int NUM_PHASES     = 10;
	localparam int PHASE_BEATS    = 200;
	localparam logic signed [127:0] Q_MAX   = 128'sh7FFF_FFFF;
	localparam logic signed [127:0] Q_MIN   = -Q_MAX - 1;
	localparam logic signed [127:0] I64_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [127:0] I64_MIN = -I64_MAX - 1;
	localparam logic signed [31:0]  S_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [31:0]  S_MIN   = 32'sh8000_0000;

	typedef struct {
		logic signed [31:0] filt;
		logic [1:0]         stat;
	} filt_res_t;

	typedef struct {
		logic               op;
		logic signed [31:0] smp;
		logic signed [31:0] yinit;
		logic               same;
		logic               known;
		logic signed [31:0] e_filt;
		logic [1:0]         e_stat;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic op = OP_FILTER;
	logic signed [31:0] sample = '0;
	logic signed [31:0] init_output = '0;
	logic same_step = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [31:0] filtered;
	logic [1:0] status;

	second_order_tustin_filter_core dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [31:0]        coef_regs [7];
	logic signed [31:0] u_hist [2];
	logic signed [31:0] y_hist [2];
	logic               primed;

	filt_res_t expected_q [$];
	int  mismatches = 0;
	int  idle_cycles = 0;
	int  stall_left = 0;
	bit  calm = 1'b0;
	dir_row_t dir_tab [16];

	function automatic logic signed [31:0] sat_q(input logic signed [127:0] v);
		if (v > Q_MAX) return S_MAX;
		if (v < Q_MIN) return S_MIN;
		return v[31:0];
	endfunction

	function automatic void bilinear(input logic signed [31:0] c0, c1, c2,
			input logic signed [127:0] t, t2,
			output logic signed [31:0] k0, k1, k2);
		logic signed [127:0] w0, w1, w2, p0, p1;
		w0 = c0;
		w1 = c1;
		w2 = c2;
		p0 = (w0 * t2) >>> 16;
		p1 = (w1 * t) >>> 16;
		k0 = sat_q(4 * w2 + p0 + 2 * p1);
		k1 = sat_q(-8 * w2 + 2 * p0);
		k2 = sat_q(4 * w2 + p0 - 2 * p1);
	endfunction

	function automatic filt_res_t filter_step(input logic o, input logic signed [31:0] u0,
			input logic signed [31:0] yi, input logic ss);
		filt_res_t r;
		logic signed [127:0] t, t2, acc, quo;
		logic [63:0] tsq;
		logic signed [31:0] b0, b1, b2, a0, a1, a2;
		r.filt = y_hist[0];
		r.stat = STATUS_OK;
		if (o == OP_INIT) begin
			u_hist[0] = u0;
			u_hist[1] = u0;
			y_hist[0] = yi;
			y_hist[1] = yi;
			primed = 1'b1;
			r.filt = yi;
		end else if (!primed) begin
			r.stat = STATUS_UNINIT;
		end else if (!ss) begin
			t = {96'b0, coef_regs[REG_STEP_SIZE]};
			tsq = {32'b0, coef_regs[REG_STEP_SIZE]} * {32'b0, coef_regs[REG_STEP_SIZE]};
			tsq = tsq >> 16;
			t2 = (tsq > 64'h7FFF_FFFF) ? Q_MAX : {64'b0, tsq};
			bilinear(coef_regs[REG_NUM_C0], coef_regs[REG_NUM_C1], coef_regs[REG_NUM_C2],
				t, t2, b0, b1, b2);
			bilinear(coef_regs[REG_DEN_C0], coef_regs[REG_DEN_C1], coef_regs[REG_DEN_C2],
				t, t2, a0, a1, a2);
			if (a0 == 0) begin
				r.stat = STATUS_DIV_ZERO;
			end else begin
				acc = 128'(b0) * 128'(u0) + 128'(b1) * 128'(u_hist[0])
					+ 128'(b2) * 128'(u_hist[1]) - 128'(a1) * 128'(y_hist[0])
					- 128'(a2) * 128'(y_hist[1]);
				if (acc > I64_MAX) acc = I64_MAX;
				if (acc < I64_MIN) acc = I64_MIN;
				quo = acc / 128'(a0);
				r.filt = sat_q(quo);
				u_hist[1] = u_hist[0];
				u_hist[0] = u0;
				y_hist[1] = y_hist[0];
				y_hist[0] = r.filt;
			end
		end
		return r;
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		coef_regs[idx] = val;
		@(posedge clk);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_beat(input logic o, input logic signed [31:0] s,
			input logic signed [31:0] yi, input logic ss, output filt_res_t r);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		op <= o;
		sample <= s;
		init_output <= yi;
		same_step <= ss;
		do @(posedge clk); while (sample_stall);
		r = filter_step(o, s, yi, ss);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return S_MAX;
			2: return S_MIN;
			default: return 32'($signed($urandom_range(0, 524288)) - 262144);
		endcase
	endfunction

	function automatic logic [31:0] rand_coef();
		if ($urandom_range(0, 5) == 0) return $urandom();
		return 32'($signed($urandom_range(0, 524288)) - 262144);
	endfunction

	task automatic program_phase(input int ph);
		logic [31:0] v [7];
		case (ph)
			1: begin
				v = '{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 32'hFFFF_FFFF};
			end
			2: begin
				v = '{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 32'd1};
			end
			3: begin
				v = '{rand_coef(), rand_coef(), rand_coef(), 32'd0, 32'd0, 32'd0, 32'd655};
			end
			4: begin
				v = '{rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
					rand_coef(), 32'd0};
			end
			default: begin
				foreach (v[i]) v[i] = rand_coef();
				v[REG_STEP_SIZE] = ($urandom_range(0, 4) == 0) ? $urandom()
					: $urandom_range(1, 32'h0001_0000);
			end
		endcase
		for (int i = 0; i < 7; i++) reg_write(3'(i), v[i]);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			stall_left = calm ? 0 : $urandom_range(0, 7);
			result_stall <= (stall_left != 0);
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= (stall_left != 0);
		end
	end

	always @(posedge clk) begin
		filt_res_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: filtered=%h status=%0d", filtered, status);
			end else begin
				e = expected_q.pop_front();
				if (filtered !== e.filt || status !== e.stat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected filtered=%h status=%0d, got filtered=%h status=%0d",
							e.filt, e.stat, filtered, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		filt_res_t r;
		logic o, ss;
		coef_regs = '{32'd65536, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd65};
		u_hist = '{0, 0};
		y_hist = '{0, 0};
		primed = 1'b0;

		dir_tab[0]  = '{OP_FILTER, 32'sd5, 32'sd0, 1'b0, 1'b1, 32'sd0, STATUS_UNINIT};
		dir_tab[1]  = '{OP_FILTER, S_MIN, S_MAX, 1'b1, 1'b1, 32'sd0, STATUS_UNINIT};
		dir_tab[2]  = '{OP_INIT, S_MAX, S_MIN, 1'b0, 1'b1, S_MIN, STATUS_OK};
		dir_tab[3]  = '{OP_FILTER, 32'sd7, 32'sd0, 1'b1, 1'b1, S_MIN, STATUS_OK};
		dir_tab[4]  = '{OP_FILTER, 32'sd0, 32'sd0, 1'b0, 1'b1, S_MIN, STATUS_DIV_ZERO};
		dir_tab[5]  = '{OP_INIT, S_MIN, S_MAX, 1'b1, 1'b1, S_MAX, STATUS_OK};
		dir_tab[6]  = '{OP_FILTER, S_MAX, 32'sd0, 1'b0, 1'b1, S_MAX, STATUS_DIV_ZERO};
		dir_tab[7]  = '{OP_INIT, 32'sd0, 32'sd0, 1'b0, 1'b0, 32'sd0, STATUS_OK};
		dir_tab[8]  = '{OP_FILTER, 32'sd65536, 32'sd0, 1'b0, 1'b0, 32'sd0, STATUS_OK};
		dir_tab[9]  = '{OP_FILTER, S_MAX, 32'sd0, 1'b0, 1'b0, 32'sd0, STATUS_OK};
		dir_tab[10] = '{OP_FILTER, S_MIN, 32'sd0, 1'b0, 1'b0, 32'sd0, STATUS_OK};
		dir_tab[11] = '{OP_FILTER, S_MIN, S_MAX, 1'b1, 1'b0, 32'sd0, STATUS_OK};
		dir_tab[12] = '{OP_FILTER, -32'sd1, 32'sd0, 1'b0, 1'b0, 32'sd0, STATUS_OK};
		dir_tab[13] = '{OP_INIT, S_MAX, S_MAX, 1'b0, 1'b0, 32'sd0, STATUS_OK};
		dir_tab[14] = '{OP_FILTER, S_MAX, 32'sd0, 1'b0, 1'b0, 32'sd0, STATUS_OK};
		dir_tab[15] = '{OP_FILTER, 32'sd0, 32'sd0, 1'b0, 1'b0, 32'sd0, STATUS_OK};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (i == 7) begin
				drain();
				reg_write(REG_NUM_C0, 32'h0001_0000);
				reg_write(REG_NUM_C1, 32'h0000_8000);
				reg_write(REG_NUM_C2, 32'h0000_4000);
				reg_write(REG_DEN_C0, 32'h0001_0000);
				reg_write(REG_DEN_C1, 32'h0002_0000);
				reg_write(REG_DEN_C2, 32'h0001_0000);
				reg_write(REG_STEP_SIZE, 32'd655);
			end
			send_beat(dir_tab[i].op, dir_tab[i].smp, dir_tab[i].yinit, dir_tab[i].same, r);
			if (dir_tab[i].known) begin
				r.filt = dir_tab[i].e_filt;
				r.stat = dir_tab[i].e_stat;
			end
			expected_q.push_back(r);
		end

		for (int ph = 1; ph <= NUM_PHASES; ph++) begin
			drain();
			calm = (ph % 4 == 0);
			program_phase(ph);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				o = (n == 0 || $urandom_range(0, 99) < 8) ? OP_INIT : OP_FILTER;
				ss = ($urandom_range(0, 9) == 0);
				send_beat(o, rand_word(), rand_word(), ss, r);
				expected_q.push_back(r);
			end
		end

		sample_valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
